[sv/kmf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmf_pkg
// Shared types and constants of the KMAC message formatter: controller
// commands, datapath status, segment phases and register indexes.
// ----------------------------------------------------------------------------
package kmf_pkg;

    localparam int unsigned LANE_BYTES  = 8;
    localparam int unsigned LANE_W      = 8 * LANE_BYTES;
    localparam int unsigned VB_W        = 4;
    localparam int unsigned SEG_CNT_W   = 9;
    localparam int unsigned IDX_W       = 4;
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned CFG_DATA_W  = 28;
    localparam int unsigned S_TDATA_W   = 8;
    localparam int unsigned S_TUSER_W   = 3;
    localparam int unsigned M_TDATA_W   = 72;
    localparam int unsigned M_TUSER_W   = 2;

    // Sponge rates in bytes for KMAC128 and KMAC256.
    localparam logic [7:0] RATE_WIDE   = 8'((1600 - 128 * 2) / 8);
    localparam logic [7:0] RATE_NARROW = 8'((1600 - 256 * 2) / 8);

    typedef enum logic [1:0] {
        PH_CUSTOM = 2'd0,
        PH_KEY    = 2'd1,
        PH_MSG    = 2'd2
    } kmf_phase_t;

    typedef enum logic [2:0] {
        CFG_RATE_SELECT   = 3'd0,
        CFG_XOF_MODE      = 3'd1,
        CFG_OUT_LEN_BYTES = 3'd2,
        CFG_KEY_LENGTH    = 3'd3,
        CFG_CUSTOM_LENGTH = 3'd4
    } kmf_cfg_idx_t;

    typedef enum logic [2:0] {
        OP_NOP    = 3'd0,
        OP_PUSH   = 3'd1,
        OP_FLUSH  = 3'd2,
        OP_FINISH = 3'd3,
        OP_ERROR  = 3'd4
    } kmf_op_t;

    typedef enum logic [2:0] {
        SRC_IN   = 3'd0,
        SRC_HELD = 3'd1,
        SRC_ZERO = 3'd2,
        SRC_HDR  = 3'd3,
        SRC_RENC = 3'd4
    } kmf_src_t;

    typedef struct packed {
        kmf_op_t            op;
        kmf_src_t           src;
        logic [IDX_W-1:0]   idx;
        logic               final_beat;
        logic               stream_end;
        logic               key_seg;
        logic               clr_count;
        logic               latch;
    } kmf_cmd_t;

    typedef struct packed {
        logic               step_ok;
        logic               data_ok;
        logic               aligned;
        logic [IDX_W-1:0]   hdr_len;
        logic [2:0]         renc_len;
    } kmf_status_t;

endpackage

[sv/kmf_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmf_datapath
// Configuration registers, byte source selection, lane packing, the hold
// stage that marks the last beat of an item, and the output register.
// ----------------------------------------------------------------------------
module kmf_datapath
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [kmf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [kmf_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic [kmf_pkg::S_TDATA_W-1:0]       s_tdata,
    input  kmf_pkg::kmf_cmd_t                   cmd,
    output kmf_pkg::kmf_status_t                status,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [kmf_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic                                m_tlast,
    output logic [kmf_pkg::M_TUSER_W-1:0]       m_tuser
);

    localparam logic [7:0] NAME_CODE [0:5] = '{8'h01, 8'h20, 8'h4B, 8'h4D, 8'h41, 8'h43};

    // Header byte: 1, w, then the name code on the customization segment,
    // then left_encode of the declared length in bits.
    function automatic logic [7:0] hdr_byte(input logic key, input logic [7:0] w,
                                            input logic [10:0] db, input logic [1:0] n,
                                            input logic [3:0] idx);
        logic [3:0] base;
        logic [3:0] j;
        logic [3:0] k;
        logic [7:0] b;
        base = key ? 4'd2 : 4'd8;
        j    = idx - base;
        k    = idx - 4'd2;
        priority if (idx == 4'd0)
            b = 8'd1;
        else if (idx == 4'd1)
            b = w;
        else if (!key && idx < 4'd8)
            b = NAME_CODE[k[2:0]];
        else if (j == 4'd0)
            b = {6'd0, n};
        else if (j == 4'd1 && n == 2'd2)
            b = {5'd0, db[10:8]};
        else
            b = db[7:0];
        return b;
    endfunction

    // right_encode byte: value bytes most significant first, then the count.
    function automatic logic [7:0] renc_byte(input logic [30:0] l, input logic [2:0] n,
                                             input logic [2:0] idx);
        logic [2:0]  k;
        logic [31:0] l32;
        logic [7:0]  b;
        k   = n - 3'd1 - idx;
        l32 = {1'b0, l};
        if (idx == n)
            b = {5'd0, n};
        else
            b = l32[{k[1:0], 3'b000} +: 8];
        return b;
    endfunction

    // Configuration registers.
    logic                               rate_sel_reg, rate_sel_next;
    logic                               xof_reg, xof_next;
    logic [27:0]                        out_len_reg, out_len_next;
    logic [7:0]                         key_len_reg, key_len_next;
    logic [6:0]                         cust_len_reg, cust_len_next;

    // Lane packing and hold stage.
    logic [kmf_pkg::LANE_W-1:0]         accum_reg, accum_next;
    logic [2:0]                         fill_reg, fill_next;
    logic [kmf_pkg::SEG_CNT_W-1:0]      sc_reg, sc_next;
    logic [7:0]                         held_reg, held_next;
    logic                               hold_valid_reg, hold_valid_next;
    logic [kmf_pkg::LANE_W-1:0]         hold_lane_reg, hold_lane_next;
    logic [kmf_pkg::VB_W-1:0]           hold_vb_reg, hold_vb_next;

    // Output register.
    logic                               out_valid_reg, out_valid_next;
    logic [kmf_pkg::LANE_W-1:0]         out_lane_reg, out_lane_next;
    logic [kmf_pkg::VB_W-1:0]           out_vb_reg, out_vb_next;
    logic                               out_rl_reg, out_rl_next;
    logic                               out_se_reg, out_se_next;
    logic                               out_err_reg, out_err_next;

    logic                               out_free;
    logic [7:0]                         w;
    logic [7:0]                         decl;
    logic [10:0]                        decl_bits;
    logic [1:0]                         hdr_n;
    logic [kmf_pkg::IDX_W-1:0]          hdr_len;
    logic [kmf_pkg::SEG_CNT_W-1:0]      bound;
    logic [30:0]                        len_bits;
    logic [2:0]                         renc_n;
    logic [7:0]                         push_byte;
    logic [kmf_pkg::LANE_W-1:0]         placed;
    logic [kmf_pkg::LANE_W-1:0]         new_lane;
    logic [kmf_pkg::VB_W-1:0]           new_vb;
    logic                               is_push;
    logic                               produce;

    assign out_free = !out_valid_reg || m_tready;

    // Values derived from the registers and the current segment.
    assign w         = rate_sel_reg ? kmf_pkg::RATE_NARROW : kmf_pkg::RATE_WIDE;
    assign decl      = cmd.key_seg ? key_len_reg : {1'b0, cust_len_reg};
    assign decl_bits = {decl, 3'b000};
    assign hdr_n     = (decl_bits[10:8] != 3'd0) ? 2'd2 : 2'd1;
    assign hdr_len   = (cmd.key_seg ? 4'd3 : 4'd9) + {2'd0, hdr_n};
    assign bound     = {5'd0, hdr_len} + {1'b0, decl};
    assign len_bits  = xof_reg ? 31'd0 : {out_len_reg, 3'b000};

    always_comb
    begin
        priority if (len_bits[30:24] != 7'd0)
            renc_n = 3'd4;
        else if (len_bits[23:16] != 8'd0)
            renc_n = 3'd3;
        else if (len_bits[15:8] != 8'd0)
            renc_n = 3'd2;
        else
            renc_n = 3'd1;
    end

    always_comb
    begin
        status.step_ok  = out_free;
        status.data_ok  = sc_reg < bound;
        status.aligned  = (sc_reg == '0) || (sc_reg == {1'b0, w}) || (sc_reg == {w, 1'b0});
        status.hdr_len  = hdr_len;
        status.renc_len = renc_n + 3'd1;
    end

    always_comb
    begin
        unique case (cmd.src)
            kmf_pkg::SRC_IN:   push_byte = s_tdata;
            kmf_pkg::SRC_HELD: push_byte = held_reg;
            kmf_pkg::SRC_ZERO: push_byte = 8'd0;
            kmf_pkg::SRC_HDR:  push_byte = hdr_byte(cmd.key_seg, w, decl_bits, hdr_n, cmd.idx);
            kmf_pkg::SRC_RENC: push_byte = renc_byte(len_bits, renc_n, cmd.idx[2:0]);
            default:           push_byte = 8'd0;
        endcase
    end

    always_comb
    begin
        placed = accum_reg;
        for (int i = 0; i < kmf_pkg::LANE_BYTES; i++)
        begin
            if (fill_reg == 3'(i))
                placed[8*i +: 8] = push_byte;
        end
    end

    always_comb
    begin
        is_push  = cmd.op == kmf_pkg::OP_PUSH;
        produce  = (is_push && fill_reg == 3'd7)
                   || (cmd.op == kmf_pkg::OP_FLUSH && fill_reg != 3'd0);
        new_lane = is_push ? placed : accum_reg;
        new_vb   = is_push ? 4'(kmf_pkg::LANE_BYTES) : {1'b0, fill_reg};

        rate_sel_next   = rate_sel_reg;
        xof_next        = xof_reg;
        out_len_next    = out_len_reg;
        key_len_next    = key_len_reg;
        cust_len_next   = cust_len_reg;
        accum_next      = accum_reg;
        fill_next       = fill_reg;
        sc_next         = sc_reg;
        held_next       = cmd.latch ? s_tdata : held_reg;
        hold_valid_next = hold_valid_reg;
        hold_lane_next  = hold_lane_reg;
        hold_vb_next    = hold_vb_reg;
        out_lane_next   = out_lane_reg;
        out_vb_next     = out_vb_reg;
        out_rl_next     = out_rl_reg;
        out_se_next     = out_se_reg;
        out_err_next    = out_err_reg;
        out_valid_next  = m_tready ? 1'b0 : out_valid_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                kmf_pkg::CFG_RATE_SELECT:   rate_sel_next = cfg_wdata[0];
                kmf_pkg::CFG_XOF_MODE:      xof_next      = cfg_wdata[0];
                kmf_pkg::CFG_OUT_LEN_BYTES: out_len_next  = cfg_wdata;
                kmf_pkg::CFG_KEY_LENGTH:    key_len_next  = cfg_wdata[7:0];
                kmf_pkg::CFG_CUSTOM_LENGTH: cust_len_next = cfg_wdata[6:0];
                default:                    ;
            endcase
        end

        if (is_push)
        begin
            accum_next = placed;
            fill_next  = fill_reg + 3'd1;
            sc_next    = sc_reg + 9'd1;
        end

        if (produce)
        begin
            accum_next = '0;
            fill_next  = 3'd0;
            if (is_push && cmd.final_beat)
            begin
                // Single-byte item: the finished lane is its only beat.
                out_valid_next = 1'b1;
                out_lane_next  = new_lane;
                out_vb_next    = new_vb;
                out_rl_next    = 1'b1;
                out_se_next    = 1'b0;
                out_err_next   = 1'b0;
            end
            else
            begin
                if (hold_valid_reg)
                begin
                    out_valid_next = 1'b1;
                    out_lane_next  = hold_lane_reg;
                    out_vb_next    = hold_vb_reg;
                    out_rl_next    = 1'b0;
                    out_se_next    = 1'b0;
                    out_err_next   = 1'b0;
                end
                hold_valid_next = 1'b1;
                hold_lane_next  = new_lane;
                hold_vb_next    = new_vb;
            end
        end

        if (cmd.op == kmf_pkg::OP_FINISH && hold_valid_reg)
        begin
            out_valid_next  = 1'b1;
            out_lane_next   = hold_lane_reg;
            out_vb_next     = hold_vb_reg;
            out_rl_next     = 1'b1;
            out_se_next     = cmd.stream_end;
            out_err_next    = 1'b0;
            hold_valid_next = 1'b0;
        end

        if (cmd.op == kmf_pkg::OP_ERROR)
        begin
            out_valid_next = 1'b1;
            out_lane_next  = '0;
            out_vb_next    = '0;
            out_rl_next    = 1'b1;
            out_se_next    = 1'b0;
            out_err_next   = 1'b1;
        end

        if (cmd.clr_count)
            sc_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_sel_reg   <= 1'b0;
            xof_reg        <= 1'b0;
            out_len_reg    <= 28'd32;
            key_len_reg    <= 8'd4;
            cust_len_reg   <= 7'd0;
            accum_reg      <= '0;
            fill_reg       <= 3'd0;
            sc_reg         <= '0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            rate_sel_reg   <= rate_sel_next;
            xof_reg        <= xof_next;
            out_len_reg    <= out_len_next;
            key_len_reg    <= key_len_next;
            cust_len_reg   <= cust_len_next;
            accum_reg      <= accum_next;
            fill_reg       <= fill_next;
            sc_reg         <= sc_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_reg      <= held_next;
        hold_lane_reg <= hold_lane_next;
        hold_vb_reg   <= hold_vb_next;
        out_lane_reg  <= out_lane_next;
        out_vb_reg    <= out_vb_next;
        out_rl_reg    <= out_rl_next;
        out_se_reg    <= out_se_next;
        out_err_reg   <= out_err_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_vb_reg, out_lane_reg};
    assign m_tlast  = out_rl_reg;
    assign m_tuser  = {out_err_reg, out_se_reg};

    // An error beat is empty and closes its item.
    a_err_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_err_reg) |-> (out_lane_reg == '0 && out_vb_reg == '0 && out_rl_reg))
        else $error("order error beat carries data");

    // The end of the stream is always the last beat of its item.
    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_se_reg) |-> out_rl_reg)
        else $error("stream end without run last");

    // Only the final lane of the stream may be partial.
    a_partial: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_err_reg && out_vb_reg != 4'(kmf_pkg::LANE_BYTES)) |-> out_se_reg)
        else $error("partial lane before stream end");

    // Finishing an item drains the hold stage.
    a_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == kmf_pkg::OP_FINISH) |=> !hold_valid_reg)
        else $error("hold stage still full after finish");

endmodule

[sv/kmf_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmf_ctrl
// Sequencer of the formatter: tracks the expected segment and steps through
// header, data, pad, right_encode, flush: one byte per cycle unless stalled.
// ----------------------------------------------------------------------------
module kmf_ctrl
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [kmf_pkg::S_TUSER_W-1:0]       s_tuser,
    input  logic                                s_tlast,
    input  kmf_pkg::kmf_status_t                status,
    output kmf_pkg::kmf_cmd_t                   cmd
);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_HDR    = 7'b0000010,
        ST_DATA   = 7'b0000100,
        ST_PAD    = 7'b0001000,
        ST_RENC   = 7'b0010000,
        ST_FLUSH  = 7'b0100000,
        ST_FINISH = 7'b1000000
    } state_t;

    state_t                         state_reg, state_next;
    kmf_pkg::kmf_phase_t            phase_reg, phase_next;
    logic                           hdr_sent_reg, hdr_sent_next;
    logic [kmf_pkg::IDX_W-1:0]      idx_reg, idx_next;
    logic                           pres_reg, pres_next;
    logic                           last_reg, last_next;
    logic                           end_reg, end_next;

    logic                           accept;
    logic [1:0]                     in_seg;
    logic                           in_pres;

    assign in_seg   = s_tuser[1:0];
    assign in_pres  = s_tuser[2];
    assign s_tready = (state_reg == ST_IDLE) && status.step_ok;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        hdr_sent_next = hdr_sent_reg;
        idx_next      = idx_reg;
        pres_next     = pres_reg;
        last_next     = last_reg;
        end_next      = end_reg;

        cmd            = '0;
        cmd.op         = kmf_pkg::OP_NOP;
        cmd.src        = kmf_pkg::SRC_ZERO;
        cmd.idx        = idx_reg;
        cmd.key_seg    = phase_reg == kmf_pkg::PH_KEY;
        cmd.stream_end = end_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_seg != phase_reg)
                        cmd.op = kmf_pkg::OP_ERROR;
                    else if (phase_reg == kmf_pkg::PH_MSG)
                    begin
                        // Message bytes are packed in the cycle they arrive.
                        if (in_pres)
                        begin
                            cmd.op         = kmf_pkg::OP_PUSH;
                            cmd.src        = kmf_pkg::SRC_IN;
                            cmd.final_beat = !s_tlast;
                        end
                        if (s_tlast)
                        begin
                            idx_next   = '0;
                            state_next = ST_RENC;
                        end
                    end
                    else
                    begin
                        cmd.latch  = 1'b1;
                        pres_next  = in_pres;
                        last_next  = s_tlast;
                        idx_next   = '0;
                        state_next = hdr_sent_reg ? ST_DATA : ST_HDR;
                    end
                end
            end

            ST_HDR:
            begin
                if (status.step_ok)
                begin
                    cmd.op  = kmf_pkg::OP_PUSH;
                    cmd.src = kmf_pkg::SRC_HDR;
                    if (idx_reg == status.hdr_len - 4'd1)
                    begin
                        hdr_sent_next = 1'b1;
                        state_next    = ST_DATA;
                    end
                    else
                        idx_next = idx_reg + 4'd1;
                end
            end

            ST_DATA:
            begin
                if (status.step_ok)
                begin
                    // Bytes beyond the declared length are dropped.
                    if (pres_reg && status.data_ok)
                    begin
                        cmd.op  = kmf_pkg::OP_PUSH;
                        cmd.src = kmf_pkg::SRC_HELD;
                    end
                    state_next = last_reg ? ST_PAD : ST_FINISH;
                end
            end

            ST_PAD:
            begin
                if (status.step_ok)
                begin
                    if (!status.aligned)
                        cmd.op = kmf_pkg::OP_PUSH;
                    else
                    begin
                        cmd.clr_count = 1'b1;
                        hdr_sent_next = 1'b0;
                        phase_next    = (phase_reg == kmf_pkg::PH_CUSTOM)
                                        ? kmf_pkg::PH_KEY : kmf_pkg::PH_MSG;
                        state_next    = ST_FINISH;
                    end
                end
            end

            ST_RENC:
            begin
                if (status.step_ok)
                begin
                    cmd.op  = kmf_pkg::OP_PUSH;
                    cmd.src = kmf_pkg::SRC_RENC;
                    if (idx_reg == {1'b0, status.renc_len} - 4'd1)
                        state_next = ST_FLUSH;
                    else
                        idx_next = idx_reg + 4'd1;
                end
            end

            ST_FLUSH:
            begin
                if (status.step_ok)
                begin
                    cmd.op        = kmf_pkg::OP_FLUSH;
                    cmd.clr_count = 1'b1;
                    phase_next    = kmf_pkg::PH_CUSTOM;
                    hdr_sent_next = 1'b0;
                    end_next      = 1'b1;
                    state_next    = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                if (status.step_ok)
                begin
                    cmd.op     = kmf_pkg::OP_FINISH;
                    end_next   = 1'b0;
                    state_next = ST_IDLE;
                end
            end

            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            phase_reg    <= kmf_pkg::PH_CUSTOM;
            hdr_sent_reg <= 1'b0;
            idx_reg      <= '0;
            pres_reg     <= 1'b0;
            last_reg     <= 1'b0;
            end_reg      <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            hdr_sent_reg <= hdr_sent_next;
            idx_reg      <= idx_next;
            pres_reg     <= pres_next;
            last_reg     <= last_next;
            end_reg      <= end_next;
        end
    end

endmodule

[sv/kmac_message_formatter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmac_message_formatter
// Builds the KMAC absorb stream (bytepad'ed customization and key, message,
// right_encode of the output length) packed into 64-bit lanes.
// ----------------------------------------------------------------------------
// Usage:
// The input stream carries one byte per beat: customization bytes, then key
// bytes, then message bytes, each segment closed by tlast. tuser gives the
// segment and a present flag; a beat with present low carries no byte but
// still opens or closes its segment. A beat for a segment other than the
// expected one is dropped and answered by one empty beat with order_error.
// The output stream carries little-endian lanes with a byte count; tlast
// marks the last lane caused by an input beat and tuser flags the final lane
// of the whole stream.
// Throughput: a message byte other than the last is taken every cycle and its
// lane appears in the cycle after the beat that completes it. The first beat
// of the customization or key segment packs its header bytes (4 to 11); each
// such beat then passes the data and finish steps before the next is taken,
// and the beat closing the segment also pads with zero bytes up to the rate.
// The last message beat is followed by its right_encode bytes (2 to 5), a
// flush of the partial lane and the finish step. The byte-wide packing unit
// writes one byte per cycle. When the receiver stalls, the output register
// holds its beat and no new byte is packed or accepted until it is taken.
// Reset restores the register defaults (KMAC128, length 32 bytes, key length
// 4, customization length 0), empties all lanes and expects customization.
// ----------------------------------------------------------------------------
module kmac_message_formatter
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [kmf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [kmf_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [kmf_pkg::S_TDATA_W-1:0]       s_tdata,   // [7:0] data_byte
    input  logic [kmf_pkg::S_TUSER_W-1:0]       s_tuser,   // [1:0] segment, [2] present
    input  logic                                s_tlast,   // seg_last
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [kmf_pkg::M_TDATA_W-1:0]       m_tdata,   // [63:0] lane, [67:64] valid_bytes
    output logic                                m_tlast,   // run_last
    output logic [kmf_pkg::M_TUSER_W-1:0]       m_tuser    // [0] stream_end, [1] order_error
);

    kmf_pkg::kmf_cmd_t      cmd;
    kmf_pkg::kmf_status_t   status;

    // The controller decides which byte is packed each cycle; the datapath
    // reports whether the output side can take a step.
    kmf_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .status   (status),
        .cmd      (cmd)
    );

    kmf_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule
